// File: hw/rtl/lru_block_cache_tags_macros.svh
// assertion helpers for the tag store checker
`ifndef LRU_BLOCK_CACHE_TAGS_MACROS_SVH
`define LRU_BLOCK_CACHE_TAGS_MACROS_SVH

// same-cycle implication
`define LBCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbct check failed");

// next-cycle implication
`define LBCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbct check failed");

`endif

// File: hw/rtl/lbct_pkg.sv
package lbct_pkg;

	localparam int TAG_W       = 32;
	localparam int CMD_W       = 2;
	localparam int SLOT_FIELD_W = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_FILL   = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

endpackage

// File: hw/rtl/lbct_ram.sv
module lbct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hw/rtl/lru_block_cache_tags.sv
// lookup without a pending fill: scans one slot at a time through the tag ram
// read port (1..SLOTS slots), then passes the response stage to the output register
// fill done, flush, pending-fill lookups and ignored items: straight to the response stage
// next item can be accepted in the cycle after the result leaves the response stage
// async reset clears valid bits, ranks (rank = slot), pending fill; tag ram not cleared
module lru_block_cache_tags #(
	parameter int SLOTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// block_number, fill_ok, zero pad
	input  logic [lbct_pkg::S_TDATA_W-1:0]  s_tdata,
	// command
	input  logic [lbct_pkg::CMD_W-1:0]      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// slot, hit, fill_request, zero pad
	output logic [lbct_pkg::M_TDATA_W-1:0]  m_tdata
);

	localparam int SW = $clog2(SLOTS);

	lbct_pkg::state_t state_q;
	lbct_pkg::cmd_t   in_cmd;

	logic [lbct_pkg::TAG_W-1:0] blk_q;
	logic [SW-1:0]              idx_q;
	logic [SW-1:0]              idx_nxt;
	logic                       inv_found_q;
	logic [SW-1:0]              inv_idx_q;
	logic                       old_found_q;
	logic [SW-1:0]              old_idx_q;

	logic [SLOTS-1:0] valid_q;
	logic [SW-1:0]    rank_q [SLOTS];
	logic [SW-1:0]    newest_rank [SLOTS];
	logic [SW-1:0]    sel_slot;
	logic [SW-1:0]    pending_q;
	logic             fill_pending_q;

	logic [lbct_pkg::SLOT_FIELD_W-1:0] res_slot_q;
	logic                              res_hit_q;
	logic                              res_fill_q;
	logic [lbct_pkg::SLOT_FIELD_W-1:0] out_slot_q;
	logic                              out_hit_q;
	logic                              out_fill_q;
	logic                              out_vld_q;
	logic                              out_free;

	logic                       accept;
	logic                       rd_en;
	logic [SW-1:0]              rd_addr;
	logic [lbct_pkg::TAG_W-1:0] rd_data;
	logic                       wr_en;
	logic [SW-1:0]              victim;

	logic          cur_valid;
	logic          cur_hit;
	logic          last_slot;
	logic [SW+1:0] idx_ext;
	logic [SW+1:0] victim_ext;
	logic [SW+1:0] pending_ext;

	assign in_cmd   = lbct_pkg::cmd_t'(s_tuser);
	assign s_tready = (state_q == lbct_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	assign idx_nxt = idx_q + SW'(1);
	assign rd_en   = accept || (state_q == lbct_pkg::ST_SCAN);
	assign rd_addr = (state_q == lbct_pkg::ST_SCAN) ? idx_nxt : '0;

	assign cur_valid = valid_q[idx_q];
	assign cur_hit   = cur_valid && (rd_data == blk_q);
	assign last_slot = (idx_q == SW'(SLOTS - 1));

	// highest invalid slot, else first slot of oldest rank, else the last slot
	always_comb begin
		if (!cur_valid) begin
			victim = idx_q;
		end else if (inv_found_q) begin
			victim = inv_idx_q;
		end else if (old_found_q) begin
			victim = old_idx_q;
		end else begin
			victim = idx_q;
		end
	end

	assign wr_en = (state_q == lbct_pkg::ST_SCAN) && !cur_hit && last_slot;

	assign sel_slot = (state_q == lbct_pkg::ST_SCAN) ? idx_q : pending_q;

	// selected slot becomes newest, younger ones age by one
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (SW'(i) == sel_slot) begin
				newest_rank[i] = '0;
			end else if (rank_q[i] < rank_q[sel_slot]) begin
				newest_rank[i] = rank_q[i] + SW'(1);
			end else begin
				newest_rank[i] = rank_q[i];
			end
		end
	end

	assign idx_ext     = {2'b00, idx_q};
	assign victim_ext  = {2'b00, victim};
	assign pending_ext = {2'b00, pending_q};

	lbct_ram #(
		.WIDTH (lbct_pkg::TAG_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (victim),
		.wr_data (blk_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= lbct_pkg::ST_IDLE;
			valid_q        <= '0;
			pending_q      <= '0;
			fill_pending_q <= 1'b0;
			out_vld_q      <= 1'b0;
			res_slot_q     <= '0;
			res_hit_q      <= 1'b0;
			res_fill_q     <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				rank_q[i] <= SW'(i);
			end
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				lbct_pkg::ST_IDLE: begin
					if (accept) begin
						state_q    <= lbct_pkg::ST_RESP;
						res_slot_q <= '0;
						res_hit_q  <= 1'b0;
						res_fill_q <= 1'b0;
						unique case (in_cmd)
							lbct_pkg::CMD_LOOKUP: begin
								if (fill_pending_q) begin
									res_slot_q <= pending_ext[1:0];
								end else begin
									state_q <= lbct_pkg::ST_SCAN;
								end
							end
							lbct_pkg::CMD_FILL: begin
								res_slot_q <= pending_ext[1:0];
								if (fill_pending_q) begin
									fill_pending_q <= 1'b0;
									if (s_tdata[lbct_pkg::TAG_W]) begin
										rank_q <= newest_rank;
									end else begin
										valid_q[pending_q] <= 1'b0;
									end
								end
							end
							lbct_pkg::CMD_FLUSH: begin
								valid_q        <= '0;
								pending_q      <= '0;
								fill_pending_q <= 1'b0;
								for (int i = 0; i < SLOTS; i++) begin
									rank_q[i] <= SW'(i);
								end
							end
							default: begin
							end
						endcase
					end
				end
				lbct_pkg::ST_SCAN: begin
					if (cur_hit) begin
						rank_q     <= newest_rank;
						res_slot_q <= idx_ext[1:0];
						res_hit_q  <= 1'b1;
						state_q    <= lbct_pkg::ST_RESP;
					end else if (last_slot) begin
						valid_q[victim] <= 1'b1;
						pending_q       <= victim;
						fill_pending_q  <= 1'b1;
						res_slot_q      <= victim_ext[1:0];
						res_fill_q      <= 1'b1;
						state_q         <= lbct_pkg::ST_RESP;
					end
				end
				lbct_pkg::ST_RESP: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= lbct_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lbct_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// scan bookkeeping and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			blk_q       <= s_tdata[lbct_pkg::TAG_W-1:0];
			idx_q       <= '0;
			inv_found_q <= 1'b0;
			old_found_q <= 1'b0;
		end else if (state_q == lbct_pkg::ST_SCAN) begin
			idx_q <= idx_nxt;
			if (!cur_valid) begin
				inv_found_q <= 1'b1;
				inv_idx_q   <= idx_q;
			end
			if (!old_found_q && (rank_q[idx_q] == SW'(SLOTS - 1))) begin
				old_found_q <= 1'b1;
				old_idx_q   <= idx_q;
			end
		end
		if ((state_q == lbct_pkg::ST_RESP) && out_free) begin
			out_slot_q <= res_slot_q;
			out_hit_q  <= res_hit_q;
			out_fill_q <= res_fill_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_fill_q, out_hit_q, out_slot_q};

endmodule

// File: hw/rtl/lbct_checker.sv
`include "lru_block_cache_tags_macros.svh"

module lbct_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lbct_pkg::M_TDATA_W-1:0] m_tdata
);

	// stalled result holds
	`LBCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// a result is never both a hit and a fill request
	`LBCT_ASSERT_NOW(a_hit_xor_fill, m_tvalid, !(m_tdata[2] && m_tdata[3]))

	// one item at a time
	`LBCT_ASSERT_NEXT(a_busy_after_item, s_tvalid && s_tready, !s_tready)

endmodule

bind lru_block_cache_tags lbct_checker u_lbct_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
